// ----- design/tpvr_pkg.sv -----
// package for the three-plane video ram scanout block
// holds payload structs, op and state codes and size constants
// no dependencies
`timescale 1ns / 1ps

package tpvr_pkg;

	// default plane size in bytes
	localparam int unsigned PLANE_BYTES_DEF = 8192;

	// field widths
	localparam int OP_W     = 3;
	localparam int OFFSET_W = 13;
	localparam int BYTE_W   = 8;
	localparam int PEN_W    = 24;
	localparam int PLANES   = 3;
	localparam int WORD_W   = PLANES * BYTE_W;

	// input op codes
	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_SEL0  = 3'd2,
		OP_SEL1  = 3'd3,
		OP_SCAN  = 3'd4
	} op_t;

	// plane select codes
	typedef enum logic [1:0] {
		SEL_P0  = 2'd0,
		SEL_P1  = 2'd1,
		SEL_P2  = 2'd2,
		SEL_ALL = 2'd3
	} sel_t;

	// result kind codes
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// control states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	// input transaction payload
	typedef struct packed {
		op_t                 op;
		logic [OFFSET_W-1:0] offset;
		logic [BYTE_W-1:0]   data;
	} item_t;

	// result transaction payload
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] read_data;
		logic [7:0]        pixel_x;
		logic [7:0]        pixel_y;
		logic              red;
		logic              green;
		logic              blue;
		logic              last;
	} result_t;

endpackage

// ----- design/three_plane_video_ram_scanout.sv -----
// top level of the three-plane video ram with scanout
// depends on tpvr_pkg and tpvr_ram
`timescale 1ns / 1ps

// Usage
// item channel (item_valid / item_stall / item) carries one op per transaction:
// write byte, read byte, set select bit 0 or 1, or scan out one byte offset.
// result channel (result_valid / result_stall / result) returns one transaction
// per read and eight per scanout (pixels msb first, last set on the final one).
// pen_we / pen_wdata write the 24-bit pen table; take effect on the next pixel.
// The three planes live side by side in one 24-bit wide ram; a plane write is a
// read-modify-write of that word.
// Sequence: a select op is applied on acceptance; a write or a read passes through
// the fetch step; a read result is loaded into the output register from that step;
// a scanout loads its first pixel after the fetch step and then one pixel per cycle
// while result_stall is low. The rate is set by the eight pixels of a scanout,
// one per cycle when not stalled, behind the single ram read per item.
// Reset: after arst_n releases, a clearing pass writes zero to every plane word
// in turn, during which item_stall is high; pen writes still land.
// A stalled result holds in the output register; pixel emission pauses and a read
// waits in its fetch step until the register frees. A new item is taken once the
// last result of the current one sits in the output register.
module three_plane_video_ram_scanout #(
	parameter int unsigned PLANE_BYTES = tpvr_pkg::PLANE_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  tpvr_pkg::item_t          item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output tpvr_pkg::result_t        result,
	input  logic                     pen_we,
	input  logic [tpvr_pkg::PEN_W-1:0] pen_wdata
);

	import tpvr_pkg::*;

	localparam int AW = $clog2(PLANE_BYTES);
	localparam logic [OFFSET_W:0] OFF_LIMIT = (OFFSET_W + 1)'(PLANE_BYTES);
	localparam logic [AW-1:0] CLR_LAST = AW'(PLANE_BYTES - 1);

	state_t state_q, state_d;

	logic [AW-1:0]       clr_q;
	logic [PEN_W-1:0]    pen_q;
	sel_t                sel_q;
	op_t                 op_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [BYTE_W-1:0]   data_q;
	logic                inside_q;
	logic [WORD_W-1:0]   pix_q;
	logic [2:0]          cnt_q;
	logic                result_valid_q;
	result_t             result_q;

	logic              accept;
	logic              out_free;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] merged;
	logic [BYTE_W-1:0] rd_byte;
	logic              load_read;
	logic              load_pix;
	logic [2:0]        color_idx;
	logic [4:0]        pen_sh;
	logic [2:0]        pen;

	// plane storage: plane 0 in the top byte, plane 2 in the bottom byte
	tpvr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(PLANE_BYTES)
	) u_planes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(item.offset[AW-1:0]),
		.rdata(ram_rdata)
	);

	// fetched word, zero beyond the planes
	assign word = inside_q ? ram_rdata : '0;

	// byte merge for a plane write
	always_comb begin
		unique case (sel_q)
			SEL_P0:  merged = {data_q, word[15:0]};
			SEL_P1:  merged = {word[23:16], data_q, word[7:0]};
			SEL_P2:  merged = {word[23:8], data_q};
			default: merged = '0;
		endcase
	end

	// read byte from the selected plane
	always_comb begin
		unique case (sel_q)
			SEL_P0:  rd_byte = word[23:16];
			SEL_P1:  rd_byte = word[15:8];
			SEL_P2:  rd_byte = word[7:0];
			default: rd_byte = '0;
		endcase
	end

	// pen lookup for the current msb column
	assign color_idx = {pix_q[23], pix_q[15], pix_q[7]};
	assign pen_sh    = 5'(color_idx) * 5'd3;
	assign pen       = pen_q[pen_sh +: 3];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && (item.op == OP_WRITE || item.op == OP_READ ||
				               item.op == OP_SCAN)) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				priority case (op_q)
					OP_SCAN: state_d = ST_EMIT;
					OP_READ: if (out_free) state_d = ST_IDLE;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_EMIT: begin
				if (out_free && cnt_q == 3'd7) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and ram control
	always_comb begin
		item_stall = (state_q != ST_IDLE);
		accept     = item_valid && !item_stall;
		out_free   = !result_valid_q || !result_stall;
		ram_we     = 1'b0;
		ram_waddr  = clr_q;
		ram_wdata  = '0;
		load_read  = 1'b0;
		load_pix   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_FETCH: begin
				if (op_q == OP_WRITE && inside_q) begin
					ram_we    = 1'b1;
					ram_waddr = offset_q[AW-1:0];
					ram_wdata = merged;
				end
				load_read = (op_q == OP_READ) && out_free;
			end
			ST_EMIT: begin
				load_pix = out_free;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			pen_q          <= '0;
			sel_q          <= SEL_P0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (pen_we) pen_q <= pen_wdata;
			// select bit updates
			if (accept && item.op == OP_SEL0) sel_q <= sel_t'({sel_q[1], item.data[0]});
			if (accept && item.op == OP_SEL1) sel_q <= sel_t'({item.data[0], sel_q[0]});
			// pixel counter
			if (state_q == ST_FETCH) cnt_q <= '0;
			else if (load_pix) cnt_q <= cnt_q + 3'd1;
			// output register occupancy
			if (load_read || load_pix) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= item.op;
			offset_q <= item.offset;
			data_q   <= item.data;
			inside_q <= ({1'b0, item.offset} < OFF_LIMIT);
		end
	end

	// pixel shift word
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			pix_q <= word;
		end else if (load_pix) begin
			pix_q <= {pix_q[22:16], 1'b0, pix_q[14:8], 1'b0, pix_q[6:0], 1'b0};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_read) begin
			result_q.kind      <= KIND_READ;
			result_q.read_data <= rd_byte;
			result_q.pixel_x   <= '0;
			result_q.pixel_y   <= '0;
			result_q.red       <= 1'b0;
			result_q.green     <= 1'b0;
			result_q.blue      <= 1'b0;
			result_q.last      <= 1'b1;
		end else if (load_pix) begin
			result_q.kind      <= KIND_PIXEL;
			result_q.read_data <= '0;
			result_q.pixel_x   <= {offset_q[4:0], cnt_q};
			result_q.pixel_y   <= offset_q[12:5];
			result_q.red       <= pen[0];
			result_q.green     <= pen[1];
			result_q.blue      <= pen[2];
			result_q.last      <= (cnt_q == 3'd7);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- design/tpvr_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tpvr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
